// ===== rtl/core/cilp_pkg.sv =====
// shared types and constants for the c integer literal parser
// character codes, limits and the character class bundle; no dependencies
package cilp_pkg;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_QUOTE  = 8'h27;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_LOW_X  = 8'h78;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;
   localparam logic [7:0] CHAR_LOW_B  = 8'h62;
   localparam logic [7:0] CHAR_LOW_F  = 8'h66;
   localparam logic [7:0] CHAR_LOW_N  = 8'h6E;
   localparam logic [7:0] CHAR_LOW_R  = 8'h72;
   localparam logic [7:0] CHAR_LOW_T  = 8'h74;
   localparam logic [7:0] CHAR_LOW_V  = 8'h76;
   localparam logic [7:0] PRINT_LO    = 8'd32;
   localparam logic [7:0] PRINT_HI    = 8'd127;
   localparam logic [7:0] LENGTH_MAX  = 8'hFF;

   // escape values
   localparam logic [3:0] ESC_VAL_A = 4'd7;
   localparam logic [3:0] ESC_VAL_B = 4'd8;
   localparam logic [3:0] ESC_VAL_F = 4'd12;
   localparam logic [3:0] ESC_VAL_N = 4'd10;
   localparam logic [3:0] ESC_VAL_R = 4'd13;
   localparam logic [3:0] ESC_VAL_T = 4'd9;
   localparam logic [3:0] ESC_VAL_V = 4'd11;

   localparam logic [1:0] ESC_DIGITS_MAX = 2'd3;

   typedef struct packed {
      logic       is_oct;
      logic       is_dec;
      logic       is_hex;
      logic [3:0] hex_val;
      logic       is_print;
   } char_class_type;

endpackage

// ===== rtl/core/cilp_char_class.sv =====
// character classifier: digit classes, hex digit value and printable check
// depends on cilp_pkg
module cilp_char_class (
   input  logic [7:0]              ch,
   output cilp_pkg::char_class_type cls
);
   import cilp_pkg::*;

   logic is_dec;
   logic is_lower_hex;
   logic is_upper_hex;

   always_comb begin
      is_dec       = (ch >= 8'h30) && (ch <= 8'h39);
      is_lower_hex = (ch >= 8'h61) && (ch <= 8'h66);
      is_upper_hex = (ch >= 8'h41) && (ch <= 8'h46);

      cls.is_dec   = is_dec;
      cls.is_oct   = (ch >= 8'h30) && (ch <= 8'h37);
      cls.is_hex   = is_dec || is_lower_hex || is_upper_hex;
      // letters a..f and A..F have low nibble 1..6
      cls.hex_val  = is_dec ? ch[3:0] : 4'(ch[3:0] + 4'd9);
      cls.is_print = (ch >= PRINT_LO) && (ch < PRINT_HI);
   end

endmodule

// ===== rtl/core/cilp_parser.sv =====
// token state machine: per character mode step, accumulator update and result
// depends on cilp_pkg
module cilp_parser #(
   parameter int VALUE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic                     start_req,
   input  logic [7:0]               ch,
   input  cilp_pkg::char_class_type cls,
   output logic                     emit,
   output logic [31:0]              value,
   output logic                     matched,
   output logic [7:0]               length
);
   import cilp_pkg::*;

   typedef enum logic [3:0] {
      M_IDLE,
      M_SIGN,
      M_ZERO,
      M_OCT,
      M_HEX0,
      M_HEX,
      M_DEC,
      M_QUOTE,
      M_ESC,
      M_ESC_OCT,
      M_CLOSE
   } mode_type;

   mode_type              mode_ff, mode_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  neg_ff, neg_in;
   logic [7:0]            cnt_ff, cnt_in;
   logic [1:0]            esc_ff, esc_in;

   logic [VALUE_BITS-1:0] acc_b;
   logic                  neg_b;
   logic [7:0]            cnt_b;
   logic [7:0]            cnt_take;
   logic [1:0]            esc_b;
   logic [1:0]            esc_inc;
   logic [VALUE_BITS-1:0] acc_oct;
   logic [VALUE_BITS-1:0] acc_hex;
   logic [VALUE_BITS-1:0] acc_dec;
   logic [VALUE_BITS-1:0] mag;
   logic                  do_match;
   logic                  do_fail;
   logic                  begin_u;

   always_comb begin
      // a start mark clears the token state before the character is applied
      acc_b = start_req ? '0 : acc_ff;
      neg_b = start_req ? 1'b0 : neg_ff;
      cnt_b = start_req ? 8'd0 : cnt_ff;
      esc_b = start_req ? 2'd0 : esc_ff;

      cnt_take = (cnt_b == LENGTH_MAX) ? cnt_b : 8'(cnt_b + 8'd1);
      esc_inc  = 2'(esc_b + 2'd1);
      acc_oct  = {acc_b[VALUE_BITS-4:0], ch[2:0]};
      acc_hex  = {acc_b[VALUE_BITS-5:0], cls.hex_val};
      acc_dec  = (acc_b << 3) + (acc_b << 1) + VALUE_BITS'(ch[3:0]);

      mode_in  = mode_ff;
      acc_in   = acc_b;
      neg_in   = neg_b;
      cnt_in   = cnt_b;
      esc_in   = esc_b;
      do_match = 1'b0;
      do_fail  = 1'b0;
      begin_u  = 1'b0;

      if (start_req) begin
         if (ch == CHAR_MINUS) begin
            neg_in  = 1'b1;
            cnt_in  = cnt_take;
            mode_in = M_SIGN;
         end else begin
            begin_u = 1'b1;
         end
      end else begin
         unique case (mode_ff)
            M_SIGN: begin
               begin_u = 1'b1;
            end
            M_ZERO: begin
               if (ch == CHAR_LOW_X) begin
                  mode_in = M_HEX0;
                  cnt_in  = cnt_take;
               end else if (cls.is_oct) begin
                  acc_in  = VALUE_BITS'(ch[2:0]);
                  mode_in = M_OCT;
                  cnt_in  = cnt_take;
               end else begin
                  do_match = 1'b1;
               end
            end
            M_OCT: begin
               if (cls.is_oct) begin
                  acc_in = acc_oct;
                  cnt_in = cnt_take;
               end else begin
                  do_match = 1'b1;
               end
            end
            M_HEX0, M_HEX: begin
               if (mode_ff == M_HEX0 && ch == CHAR_NUL) begin
                  do_fail = 1'b1;
               end else if (cls.is_hex) begin
                  acc_in  = acc_hex;
                  mode_in = M_HEX;
                  cnt_in  = cnt_take;
               end else begin
                  do_match = 1'b1;
               end
            end
            M_DEC: begin
               if (cls.is_dec) begin
                  acc_in = acc_dec;
                  cnt_in = cnt_take;
               end else begin
                  do_match = 1'b1;
               end
            end
            M_QUOTE: begin
               if (ch == CHAR_BSLASH) begin
                  mode_in = M_ESC;
                  cnt_in  = cnt_take;
               end else if (ch == CHAR_QUOTE || !cls.is_print) begin
                  do_fail = 1'b1;
               end else begin
                  acc_in  = VALUE_BITS'(ch);
                  mode_in = M_CLOSE;
                  cnt_in  = cnt_take;
               end
            end
            M_ESC: begin
               if (ch == CHAR_NUL) begin
                  do_fail = 1'b1;
               end else begin
                  cnt_in  = cnt_take;
                  mode_in = M_CLOSE;
                  case (ch)
                     CHAR_LOW_A: acc_in = VALUE_BITS'(ESC_VAL_A);
                     CHAR_LOW_B: acc_in = VALUE_BITS'(ESC_VAL_B);
                     CHAR_LOW_F: acc_in = VALUE_BITS'(ESC_VAL_F);
                     CHAR_LOW_N: acc_in = VALUE_BITS'(ESC_VAL_N);
                     CHAR_LOW_R: acc_in = VALUE_BITS'(ESC_VAL_R);
                     CHAR_LOW_T: acc_in = VALUE_BITS'(ESC_VAL_T);
                     CHAR_LOW_V: acc_in = VALUE_BITS'(ESC_VAL_V);
                     default: begin
                        if (cls.is_oct) begin
                           acc_in  = VALUE_BITS'(ch[2:0]);
                           esc_in  = 2'd1;
                           mode_in = M_ESC_OCT;
                        end else begin
                           // any other escaped character stands for itself
                           acc_in = VALUE_BITS'(ch);
                        end
                     end
                  endcase
               end
            end
            M_ESC_OCT: begin
               if (cls.is_oct) begin
                  acc_in = acc_oct;
                  cnt_in = cnt_take;
                  esc_in = esc_inc;
                  if (esc_inc >= ESC_DIGITS_MAX) begin
                     mode_in = M_CLOSE;
                  end
               end else if (ch == CHAR_QUOTE) begin
                  cnt_in   = cnt_take;
                  do_match = 1'b1;
               end else begin
                  do_fail = 1'b1;
               end
            end
            M_CLOSE: begin
               if (ch == CHAR_QUOTE) begin
                  cnt_in   = cnt_take;
                  do_match = 1'b1;
               end else begin
                  do_fail = 1'b1;
               end
            end
            default: begin
               mode_in = M_IDLE;
            end
         endcase
      end

      // first character of the unsigned part
      if (begin_u) begin
         if (ch == CHAR_ZERO) begin
            mode_in = M_ZERO;
            cnt_in  = cnt_take;
         end else if (cls.is_dec) begin
            acc_in  = VALUE_BITS'(ch[3:0]);
            mode_in = M_DEC;
            cnt_in  = cnt_take;
         end else if (ch == CHAR_QUOTE) begin
            mode_in = M_QUOTE;
            cnt_in  = cnt_take;
         end else begin
            do_fail = 1'b1;
         end
      end

      if (do_match || do_fail) begin
         mode_in = M_IDLE;
      end

      mag     = neg_b ? (VALUE_BITS'(0) - acc_b) : acc_b;
      emit    = do_match || do_fail;
      matched = do_match;
      value   = do_match ? 32'(signed'(mag)) : 32'd0;
      length  = do_match ? cnt_in : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         acc_ff  <= '0;
         neg_ff  <= 1'b0;
         cnt_ff  <= 8'd0;
         esc_ff  <= 2'd0;
      end else if (step_en) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         neg_ff  <= neg_in;
         cnt_ff  <= cnt_in;
         esc_ff  <= esc_in;
      end
   end

endmodule

// ===== rtl/core/c_integer_literal_parser_unit.sv =====
// c integer literal parser: one character per transaction, one result per token
// latency: a result reaches rsp after the deciding character has passed the input register and the result register
// throughput: one character per cycle while rsp does not stall, set by the single mode step in cilp_parser
// reset (synchronous, active high) empties the input and result registers and closes any token
// depends on cilp_pkg, cilp_char_class and cilp_parser
module c_integer_literal_parser_unit #(
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // character stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tuser,   // [0] start_req
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] value, [39:32] length
   output logic        rsp_tuser    // [0] matched
);
   import cilp_pkg::*;

   // input register
   logic       in_valid_ff;
   logic       in_start_ff;
   logic [7:0] in_ch_ff;

   // result register
   logic        rsp_valid_ff;
   logic [31:0] value_ff;
   logic        matched_ff;
   logic [7:0]  length_ff;

   logic           advance;
   char_class_type cls;
   logic           emit;
   logic [31:0]    value;
   logic           matched;
   logic [7:0]     length;

   // the held character steps the parser once the result slot is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   // input register refills in the same cycle it is consumed
   assign req_tready = !in_valid_ff || advance;

   cilp_char_class u_class (
      .ch  (in_ch_ff),
      .cls (cls)
   );

   cilp_parser #(
      .VALUE_BITS (VALUE_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .start_req (in_start_ff),
      .ch        (in_ch_ff),
      .cls       (cls),
      .emit      (emit),
      .value     (value),
      .matched   (matched),
      .length    (length)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // payload of the input register needs no reset
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_start_ff <= req_tuser;
         in_ch_ff    <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         // a decided token loads the result register
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         value_ff   <= value;
         matched_ff <= matched;
         length_ff  <= length;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {length_ff, value_ff};
   assign rsp_tuser  = matched_ff;

endmodule

// ===== tb/cilp_checker.sv =====
`timescale 1ns / 1ps
// checker for the c integer literal parser: watches both streams, predicts each token result
// and compares it with the result stream; depends on cilp_pkg only
module cilp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tuser,   // [0] start_req
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [31:0] value, [39:32] length
   input  logic        rsp_tuser,   // [0] matched
   output int          fail_count,
   output int          pending_count
);
   import cilp_pkg::*;

   typedef enum logic [3:0] {
      PM_IDLE, PM_SIGN, PM_ZERO, PM_OCT, PM_HEX0, PM_HEX, PM_DEC,
      PM_QUOTE, PM_ESC, PM_ESC_OCT, PM_CLOSE
   } parse_mode_type;

   typedef struct packed {
      logic [31:0] value;
      logic        matched;
      logic [7:0]  length;
   } literal_result_type;

   parse_mode_type     mode;
   logic [31:0]        acc;
   logic               negative;
   logic [7:0]         consumed;
   logic [1:0]         esc_digits;
   literal_result_type expected_literals[$];
   literal_result_type predicted;
   literal_result_type oldest;
   literal_result_type seen;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      fail_count++;
   endtask

   function automatic void count_char();
      if (consumed != LENGTH_MAX) begin
         consumed = consumed + 8'd1;
      end
   endfunction

   function automatic literal_result_type close_failed();
      mode = PM_IDLE;
      return '0;
   endfunction

   function automatic literal_result_type close_matched();
      literal_result_type r;
      r.value   = negative ? -acc : acc;
      r.matched = 1'b1;
      r.length  = consumed;
      mode      = PM_IDLE;
      return r;
   endfunction

   function automatic bit is_oct(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= "7";
   endfunction

   function automatic bit is_dec(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= "9";
   endfunction

   function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] n);
      n = '0;
      if (is_dec(c)) begin
         n = c[3:0];
         return 1'b1;
      end
      if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
         n = c[3:0] + 4'd9;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // first character after the optional sign
   function automatic bit begin_number(input logic [7:0] c,
                                       output literal_result_type r);
      r = '0;
      if (c == CHAR_ZERO) begin
         mode = PM_ZERO;
         count_char();
         return 1'b0;
      end
      if (c >= "1" && c <= "9") begin
         acc  = {28'd0, c[3:0]};
         mode = PM_DEC;
         count_char();
         return 1'b0;
      end
      if (c == CHAR_QUOTE) begin
         mode = PM_QUOTE;
         count_char();
         return 1'b0;
      end
      r = close_failed();
      return 1'b1;
   endfunction

   // one character step; returns 1 when the token is decided
   function automatic bit predict_char(input logic start, input logic [7:0] c,
                                       output literal_result_type r);
      logic [3:0] nib;
      r = '0;
      if (start) begin
         acc        = '0;
         negative   = 1'b0;
         consumed   = '0;
         esc_digits = '0;
         if (c == CHAR_MINUS) begin
            negative = 1'b1;
            count_char();
            mode = PM_SIGN;
            return 1'b0;
         end
         return begin_number(c, r);
      end
      case (mode)
         PM_SIGN: return begin_number(c, r);
         PM_ZERO: begin
            if (c == CHAR_LOW_X) begin
               mode = PM_HEX0;
               count_char();
               return 1'b0;
            end
            if (is_oct(c)) begin
               acc  = {29'd0, c[2:0]};
               mode = PM_OCT;
               count_char();
               return 1'b0;
            end
            r = close_matched();
            return 1'b1;
         end
         PM_OCT: begin
            if (is_oct(c)) begin
               acc = {acc[28:0], c[2:0]};
               count_char();
               return 1'b0;
            end
            r = close_matched();
            return 1'b1;
         end
         PM_HEX0, PM_HEX: begin
            // "0x" straight into end of string fails, any other non-hex ends a match
            if (mode == PM_HEX0 && c == CHAR_NUL) begin
               r = close_failed();
               return 1'b1;
            end
            if (hex_nibble(c, nib)) begin
               acc  = {acc[27:0], nib};
               mode = PM_HEX;
               count_char();
               return 1'b0;
            end
            r = close_matched();
            return 1'b1;
         end
         PM_DEC: begin
            if (is_dec(c)) begin
               acc = acc * 32'd10 + {28'd0, c[3:0]};
               count_char();
               return 1'b0;
            end
            r = close_matched();
            return 1'b1;
         end
         PM_QUOTE: begin
            if (c == CHAR_BSLASH) begin
               mode = PM_ESC;
               count_char();
               return 1'b0;
            end
            if (c == CHAR_QUOTE || c < PRINT_LO || c >= PRINT_HI) begin
               r = close_failed();
               return 1'b1;
            end
            acc  = {24'd0, c};
            mode = PM_CLOSE;
            count_char();
            return 1'b0;
         end
         PM_ESC: begin
            if (c == CHAR_NUL) begin
               r = close_failed();
               return 1'b1;
            end
            count_char();
            mode = PM_CLOSE;
            case (c)
               CHAR_LOW_A: acc = {28'd0, ESC_VAL_A};
               CHAR_LOW_B: acc = {28'd0, ESC_VAL_B};
               CHAR_LOW_F: acc = {28'd0, ESC_VAL_F};
               CHAR_LOW_N: acc = {28'd0, ESC_VAL_N};
               CHAR_LOW_R: acc = {28'd0, ESC_VAL_R};
               CHAR_LOW_T: acc = {28'd0, ESC_VAL_T};
               CHAR_LOW_V: acc = {28'd0, ESC_VAL_V};
               default: begin
                  if (is_oct(c)) begin
                     acc        = {29'd0, c[2:0]};
                     esc_digits = 2'd1;
                     mode       = PM_ESC_OCT;
                  end else begin
                     // any other escaped byte stands for itself
                     acc = {24'd0, c};
                  end
               end
            endcase
            return 1'b0;
         end
         PM_ESC_OCT: begin
            if (is_oct(c)) begin
               acc = {acc[28:0], c[2:0]};
               count_char();
               esc_digits = esc_digits + 2'd1;
               if (esc_digits >= ESC_DIGITS_MAX) begin
                  mode = PM_CLOSE;
               end
               return 1'b0;
            end
            if (c == CHAR_QUOTE) begin
               count_char();
               r = close_matched();
               return 1'b1;
            end
            r = close_failed();
            return 1'b1;
         end
         PM_CLOSE: begin
            if (c == CHAR_QUOTE) begin
               count_char();
               r = close_matched();
               return 1'b1;
            end
            r = close_failed();
            return 1'b1;
         end
         default: begin
            // no token open: the character is dropped
            mode = PM_IDLE;
            return 1'b0;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         mode       = PM_IDLE;
         acc        = '0;
         negative   = 1'b0;
         consumed   = '0;
         esc_digits = '0;
         expected_literals.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            if (predict_char(req_tuser, req_tdata, predicted)) begin
               expected_literals.push_back(predicted);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.value   = rsp_tdata[31:0];
            seen.length  = rsp_tdata[39:32];
            seen.matched = rsp_tuser;
            if (expected_literals.size() == 0) begin
               report_mismatch($sformatf(
                  "result with none pending: value %0d matched %0d length %0d",
                  $signed(seen.value), seen.matched, seen.length));
            end else begin
               oldest = expected_literals.pop_front();
               if (seen.value !== oldest.value) begin
                  report_mismatch($sformatf("value %0d, predicted %0d",
                                            $signed(seen.value), $signed(oldest.value)));
               end
               if (seen.matched !== oldest.matched) begin
                  report_mismatch($sformatf("matched %0d, predicted %0d",
                                            seen.matched, oldest.matched));
               end
               if (seen.length !== oldest.length) begin
                  report_mismatch($sformatf("length %0d, predicted %0d",
                                            seen.length, oldest.length));
               end
            end
         end
      end
      pending_count <= expected_literals.size();
   end

endmodule

// ===== tb/tb_c_integer_literal_parser_unit.sv =====
`timescale 1ns / 1ps
// top of the c integer literal parser testbench: clock, reset, character stimulus, result
// back-pressure and the verdict; depends on cilp_pkg, cilp_checker and the parser unit
module tb_c_integer_literal_parser_unit;
   import cilp_pkg::*;

   localparam int    RANDOM_ITEMS  = 690;
   localparam int    IDLE_PERCENT  = 37;
   localparam int    DRAIN_CYCLES  = 20;    // extra wait for stray results after the pending ones
   localparam int    SETTLE_LIMIT  = 5000;
   localparam int    RUN_LIMIT_NS  = 2_000_000;
   localparam string DEC_DIGITS    = "0123456789";
   localparam string OCT_DIGITS    = "01234567";
   localparam string HEX_DIGITS    = "0123456789abcdefABCDEF";
   localparam string ESC_LETTERS   = "abfnrtv\\'\"q?";
   localparam string TRICKY_CHARS  = "0123456789xX'\\-\"abfnrtv ";

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;    // [7:0] ch
   logic        req_tuser  = 1'b0;  // [0] start_req
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // [31:0] value, [39:32] length
   logic        rsp_tuser;          // [0] matched

   int          fail_count;
   int          pending_count;
   bit          steady = 1'b0;      // set for the stretch with no idling on either side
   int          item_count = 0;
   int          token_index;
   int          settle_cycles;
   logic [7:0]  token_chars[$];

   c_integer_literal_parser_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   cilp_checker literal_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // result side back-pressure, stalls about a third of the time outside the steady stretch
   always @(posedge clock) begin
      rsp_tready <= !reset && (steady || $urandom_range(99) >= IDLE_PERCENT);
   end

   // one character transaction; valid is only dropped when a gap is taken
   task automatic send_char(input logic start, input logic [7:0] c);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   // sends the collected characters as one token, start on the first
   task automatic send_token();
      foreach (token_chars[i]) begin
         send_char(i == 0, token_chars[i]);
      end
      item_count += token_chars.size();
      token_chars.delete();
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         token_chars.push_back(s[i]);
      end
   endtask

   task automatic send_text(input string s);
      push_text(s);
      send_token();
   endtask

   task automatic push_digits(input int n, input string alphabet);
      for (int i = 0; i < n; i++) begin
         token_chars.push_back(alphabet[$urandom_range(alphabet.len() - 1)]);
      end
   endtask

   function automatic bit in_set(input logic [7:0] c, input string set);
      for (int i = 0; i < set.len(); i++) begin
         if (set[i] == c) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic logic [7:0] pick_outside(input string set);
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(255));
      end while (in_set(c, set));
      return c;
   endfunction

   // character that ends a number: end of string now and then, else any non-digit
   function automatic logic [7:0] end_char(input string set);
      if ($urandom_range(7) == 0) begin
         return CHAR_NUL;
      end
      return pick_outside(set);
   endfunction

   // builds one random token into token_chars, mostly well formed
   task automatic build_token(input int kind);
      int         n;
      logic [7:0] c;
      if (kind < 75 && $urandom_range(3) == 0) begin
         token_chars.push_back(CHAR_MINUS);
      end
      if (token_index == 3) begin
         // long decimal, length saturates
         token_chars.push_back("7");
         push_digits(280, DEC_DIGITS);
         token_chars.push_back(" ");
      end else if (token_index == 30) begin
         push_text("0x");
         push_digits(270, HEX_DIGITS);
         token_chars.push_back(",");
      end else if (kind < 20) begin
         token_chars.push_back(CHAR_ZERO + 8'($urandom_range(1, 9)));
         push_digits($urandom_range(12), DEC_DIGITS);
         token_chars.push_back(end_char(DEC_DIGITS));
      end else if (kind < 35) begin
         push_text("0x");
         push_digits($urandom_range(9), HEX_DIGITS);
         token_chars.push_back(end_char(HEX_DIGITS));
      end else if (kind < 47) begin
         token_chars.push_back(CHAR_ZERO);
         n = $urandom_range(12);
         push_digits(n, OCT_DIGITS);
         token_chars.push_back(n == 0 ? end_char({OCT_DIGITS, "x"}) : end_char(OCT_DIGITS));
      end else if (kind < 57) begin
         do begin
            c = 8'($urandom_range(PRINT_LO, PRINT_HI - 1));
         end while (c == CHAR_QUOTE || c == CHAR_BSLASH);
         token_chars.push_back(CHAR_QUOTE);
         token_chars.push_back(c);
         token_chars.push_back(CHAR_QUOTE);
      end else if (kind < 67) begin
         push_text("'\\");
         if ($urandom_range(1)) begin
            token_chars.push_back(ESC_LETTERS[$urandom_range(ESC_LETTERS.len() - 1)]);
         end else begin
            do begin
               c = pick_outside(OCT_DIGITS);
            end while (c == CHAR_NUL);
            token_chars.push_back(c);
         end
         token_chars.push_back(CHAR_QUOTE);
      end else if (kind < 75) begin
         push_text("'\\");
         push_digits($urandom_range(1, 3), OCT_DIGITS);
         token_chars.push_back(CHAR_QUOTE);
      end else begin
         // broken: a short run of characters that often start a literal
         n = $urandom_range(1, 5);
         for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(2) == 0) begin
               token_chars.push_back(8'($urandom_range(255)));
            end else begin
               token_chars.push_back(TRICKY_CHARS[$urandom_range(TRICKY_CHARS.len() - 1)]);
            end
         end
      end
   endtask

   initial begin
      int kind;
      int n;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: bare zero, signs, bases, limits and wrap
      send_text("0 ");
      send_text("-09");
      send_text("-0xg");                 // empty hex before a non-hex character
      push_text("0x");
      token_chars.push_back(CHAR_NUL);   // empty hex at end of string
      send_token();
      send_text("0xFFFFFFFF,");
      push_text("-0xdeadBEEF");
      token_chars.push_back(CHAR_NUL);
      send_token();
      send_text("017 ");
      send_text("-2147483648 ");
      send_text("4294967296 ");

      // quoted characters: printable limits, named and other escapes, octal escapes
      send_text("' '");
      send_text("'~'");
      for (int i = 0; i < ESC_LETTERS.len(); i++) begin
         push_text("'\\");
         token_chars.push_back(ESC_LETTERS[i]);
         send_text("'");
      end
      send_text("'\\101'");
      send_text("'\\777'");
      send_text("'\\1234'");
      push_text("'\\");
      token_chars.push_back(8'hFF);
      send_text("'");
      push_text("'\\");
      token_chars.push_back(CHAR_NUL);   // backslash at end of string
      send_token();

      // failures: bad quoted forms, no digit after sign
      send_text("''");
      token_chars.push_back(CHAR_QUOTE);
      token_chars.push_back(PRINT_HI);
      send_text("'");
      send_text("'ab");
      send_text("--");
      send_text("x");

      // restart while a token is open, then characters while idle
      send_text("12");
      send_text("7 ");
      send_char(1'b0, "z");
      send_char(1'b0, CHAR_NUL);

      // random part; a steady stretch in the middle has no idling on either side
      item_count  = 0;
      token_index = 0;
      while (item_count < RANDOM_ITEMS) begin
         steady = item_count >= 350 && item_count < 550;
         kind   = $urandom_range(99);
         if (kind >= 92 && token_index != 3 && token_index != 30) begin
            // noise with random start marks
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
               send_char(1'($urandom_range(1)), 8'($urandom_range(255)));
            end
            item_count += n;
         end else begin
            build_token(kind);
            send_token();
         end
         // now and then a few characters with no start mark after the token
         if ($urandom_range(9) == 0) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
               send_char(1'b0, 8'($urandom_range(255)));
            end
         end
         token_index++;
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      // drain: wait for outstanding results, then wait on for strays
      settle_cycles = 0;
      while (pending_count != 0 && settle_cycles < SETTLE_LIMIT) begin
         @(posedge clock);
         settle_cycles++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("Verification failed");
      $finish;
   end

endmodule
